// ----- src/checked_integer_alu_assert.svh -----
// ----------------------------------------------------------------------------
// checked_integer_alu assertion macros
// Property wrappers clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHECKED_INTEGER_ALU_ASSERT_SVH
`define CHECKED_INTEGER_ALU_ASSERT_SVH

// same-cycle implication
`define CIA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checked_integer_alu: property failed");

// next-cycle implication
`define CIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checked_integer_alu: property failed");

`endif

// ----- src/cia_pkg.sv -----
// ----------------------------------------------------------------------------
// cia_pkg
// Widths, codes, types and helpers shared by the checked integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int DATA_W    = 64;
  localparam int IO_W      = 64;
  localparam int HALF_W    = (DATA_W + 1) / 2;
  localparam int MAG_W     = 2 * HALF_W;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int SH_W      = $clog2(MAG_W + 1);
  localparam int BIT_CNT_W = $clog2(DATA_W + 1);
  localparam int LOOP_W    = 7;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [2:0]        code_t;

  localparam code_t OP_ADD  = 3'd0;
  localparam code_t OP_SUB  = 3'd1;
  localparam code_t OP_MUL  = 3'd2;
  localparam code_t OP_DIV  = 3'd3;
  localparam code_t OP_POW  = 3'd4;
  localparam code_t OP_FACT = 3'd5;

  localparam code_t ST_OK      = 3'd0;
  localparam code_t ST_OVF     = 3'd1;
  localparam code_t ST_DIV0    = 3'd2;
  localparam code_t ST_NEGEXP  = 3'd3;
  localparam code_t ST_NEGFACT = 3'd4;

  localparam word_t MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t ONE     = word_t'(1);

  typedef struct packed {
    logic done;
    logic ovf;
  } unit_rsp_t;

  function automatic word_t magnitude(input word_t v);
    return v[DATA_W-1] ? (~v + ONE) : v;
  endfunction

endpackage

// ----- src/checked_integer_alu.sv -----
// ----------------------------------------------------------------------------
// checked_integer_alu
// Overflow-checked signed integer ALU: add, subtract, multiply, divide,
// power and factorial under one sequencer with a shared multiplier.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays
// high until the result strobe, and the result and status appear on
// out_result/out_status for exactly one cycle with out_valid, which the
// receiver cannot hold off. Add, subtract and errors found on the operands
// are settled in the dispatch state; multiply and divide wait for their
// unit. Power and factorial run a chain of checked multiplies on the one
// shared multiplier, stopping at the first step that overflows, up to 64
// steps for power and up to 20 for factorial. The multiplier builds each
// product from four half-width partial products, one per cycle; the
// divider retires one quotient bit per cycle.
module checked_integer_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  output logic        out_valid,
  output logic [63:0] out_result,
  output logic [2:0]  out_status
);

  localparam int W  = cia_pkg::DATA_W;
  localparam int LW = cia_pkg::LOOP_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_LOOP   = 3'd3;
  localparam logic [2:0] S_LOOP_W = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;

  logic [2:0]             state_r;
  logic [2:0]             state_nxt;
  cia_pkg::code_t         op_r;
  cia_pkg::word_t         a_r;
  cia_pkg::word_t         b_r;
  cia_pkg::word_t         acc_r;
  cia_pkg::word_t         acc_nxt;
  logic [LW-1:0]          cnt_r;
  logic [LW-1:0]          cnt_nxt;
  logic                   out_valid_r;
  logic [63:0]            out_result_r;
  cia_pkg::code_t         out_status_r;

  logic                   fin;
  cia_pkg::word_t         fin_res;
  cia_pkg::code_t         fin_st;
  logic                   sub;
  logic [W:0]             a_ext;
  logic [W:0]             b_ext;
  logic [W:0]             sum;
  logic                   loop_more;
  logic                   mul_start;
  logic                   div_start;
  cia_pkg::word_t         mul_x;
  cia_pkg::word_t         mul_y;
  cia_pkg::word_t         mul_prod;
  cia_pkg::word_t         div_quo;
  cia_pkg::unit_rsp_t     mul_rsp;
  cia_pkg::unit_rsp_t     div_rsp;

  cia_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .prod  (mul_prod),
    .rsp   (mul_rsp)
  );

  cia_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .x     (a_r),
    .y     (b_r),
    .quo   (div_quo),
    .rsp   (div_rsp)
  );

  always_comb begin
    sub   = (op_r == cia_pkg::OP_SUB);
    a_ext = {a_r[W-1], a_r};
    b_ext = {b_r[W-1], b_r};
    sum   = a_ext + (sub ? ~b_ext : b_ext) + {{W{1'b0}}, sub};

    if (op_r == cia_pkg::OP_POW) begin
      loop_more = cia_pkg::word_t'(cnt_r) < b_r;
    end else begin
      loop_more = cia_pkg::word_t'(cnt_r) <= a_r;
    end

    mul_x = (op_r == cia_pkg::OP_MUL) ? a_r : acc_r;
    if (op_r == cia_pkg::OP_MUL) begin
      mul_y = b_r;
    end else if (op_r == cia_pkg::OP_POW) begin
      mul_y = a_r;
    end else begin
      mul_y = cia_pkg::word_t'(cnt_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    fin       = 1'b0;
    fin_res   = '0;
    fin_st    = cia_pkg::ST_OK;
    mul_start = 1'b0;
    div_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DISP;
      end
      S_DISP: begin
        unique case (op_r) inside
          cia_pkg::OP_ADD, cia_pkg::OP_SUB: begin
            fin = 1'b1;
            if (sum[W] ^ sum[W-1]) begin
              fin_st = cia_pkg::ST_OVF;
            end else begin
              fin_res = sum[W-1:0];
            end
          end
          cia_pkg::OP_MUL: begin
            mul_start = 1'b1;
            state_nxt = S_MUL;
          end
          cia_pkg::OP_DIV: begin
            if (b_r == '0) begin
              fin    = 1'b1;
              fin_st = cia_pkg::ST_DIV0;
            end else if (a_r == cia_pkg::MIN_VAL && b_r == '1) begin
              fin    = 1'b1;
              fin_st = cia_pkg::ST_OVF;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          cia_pkg::OP_POW: begin
            if (b_r[W-1]) begin
              fin    = 1'b1;
              fin_st = cia_pkg::ST_NEGEXP;
            end else if (b_r == '0) begin
              fin     = 1'b1;
              fin_res = cia_pkg::ONE;
            end else if (a_r == '0 || a_r == cia_pkg::ONE) begin
              fin     = 1'b1;
              fin_res = a_r;
            end else if (a_r == '1) begin
              fin     = 1'b1;
              fin_res = b_r[0] ? '1 : cia_pkg::ONE;
            end else begin
              acc_nxt   = cia_pkg::ONE;
              cnt_nxt   = '0;
              state_nxt = S_LOOP;
            end
          end
          cia_pkg::OP_FACT: begin
            if (a_r[W-1]) begin
              fin    = 1'b1;
              fin_st = cia_pkg::ST_NEGFACT;
            end else begin
              acc_nxt   = cia_pkg::ONE;
              cnt_nxt   = LW'(2);
              state_nxt = S_LOOP;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_MUL: begin
        if (mul_rsp.done) begin
          fin = 1'b1;
          if (mul_rsp.ovf) begin
            fin_st = cia_pkg::ST_OVF;
          end else begin
            fin_res = mul_prod;
          end
        end
      end
      S_LOOP: begin
        if (loop_more) begin
          mul_start = 1'b1;
          state_nxt = S_LOOP_W;
        end else begin
          fin     = 1'b1;
          fin_res = acc_r;
        end
      end
      S_LOOP_W: begin
        if (mul_rsp.done) begin
          if (mul_rsp.ovf) begin
            fin    = 1'b1;
            fin_st = cia_pkg::ST_OVF;
          end else begin
            acc_nxt   = mul_prod;
            cnt_nxt   = cnt_r + LW'(1);
            state_nxt = S_LOOP;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          fin     = 1'b1;
          fin_res = div_quo;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) state_nxt = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op_r <= in_opcode;
      a_r  <= in_operand_a[W-1:0];
      b_r  <= in_operand_b[W-1:0];
    end
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (fin) begin
      out_result_r <= 64'(signed'(fin_res));
      out_status_r <= fin_st;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_status = out_status_r;

endmodule

// ----- src/cia_mul.sv -----
// ----------------------------------------------------------------------------
// cia_mul
// Checked signed multiplier: four half-width partial products,
// accumulated into a double-width magnitude, then range checked.
// ----------------------------------------------------------------------------
module cia_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  cia_pkg::word_t     x,
  input  cia_pkg::word_t     y,
  output cia_pkg::word_t     prod,
  output cia_pkg::unit_rsp_t rsp
);

  localparam int W  = cia_pkg::DATA_W;
  localparam int H  = cia_pkg::HALF_W;
  localparam int M  = cia_pkg::MAG_W;
  localparam int P  = cia_pkg::PROD_W;
  localparam int SW = cia_pkg::SH_W;

  localparam logic [2:0] PH_PP_LAST = 3'd3;
  localparam logic [2:0] PH_FIN     = 3'd5;

  logic                run_r;
  logic [2:0]          ph_r;
  logic                done_r;
  logic                ovf_r;
  logic                neg_r;
  logic [M-1:0]        xm_r;
  logic [M-1:0]        ym_r;
  logic [M-1:0]        pp_r;
  logic [SW-1:0]       sh_r;
  logic [P-1:0]        acc_r;
  cia_pkg::word_t      prod_r;

  logic [H-1:0]        xh;
  logic [H-1:0]        yh;
  logic [P-1:0]        lim;
  cia_pkg::word_t      mag_low;

  always_comb begin
    xh      = ph_r[0] ? xm_r[M-1:H] : xm_r[H-1:0];
    yh      = ph_r[1] ? ym_r[M-1:H] : ym_r[H-1:0];
    lim     = P'(cia_pkg::MIN_VAL) - (neg_r ? P'(0) : P'(1));
    mag_low = acc_r[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && run_r && (ph_r == PH_FIN);
      if (start) begin
        run_r <= 1'b1;
        ph_r  <= '0;
      end else if (run_r) begin
        ph_r <= ph_r + 3'd1;
        if (ph_r == PH_FIN) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= x[W-1] ^ y[W-1];
      xm_r  <= M'(cia_pkg::magnitude(x));
      ym_r  <= M'(cia_pkg::magnitude(y));
      acc_r <= '0;
    end else if (run_r) begin
      if (ph_r <= PH_PP_LAST) begin
        pp_r <= {{H{1'b0}}, xh} * {{H{1'b0}}, yh};
        if (ph_r[0] & ph_r[1]) begin
          sh_r <= SW'(M);
        end else if (ph_r[0] ^ ph_r[1]) begin
          sh_r <= SW'(H);
        end else begin
          sh_r <= '0;
        end
      end
      if (ph_r != 3'd0 && ph_r < PH_FIN) begin
        acc_r <= acc_r + (P'(pp_r) << sh_r);
      end
      if (ph_r == PH_FIN) begin
        ovf_r  <= acc_r > lim;
        prod_r <= neg_r ? (~mag_low + cia_pkg::ONE) : mag_low;
      end
    end
  end

  always_comb begin
    prod     = prod_r;
    rsp.done = done_r;
    rsp.ovf  = ovf_r;
  end

endmodule

// ----- src/cia_div.sv -----
// ----------------------------------------------------------------------------
// cia_div
// Signed divider truncating toward zero: restoring, one quotient bit per
// cycle on operand magnitudes, sign applied at the end.
// ----------------------------------------------------------------------------
module cia_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  cia_pkg::word_t     x,
  input  cia_pkg::word_t     y,
  output cia_pkg::word_t     quo,
  output cia_pkg::unit_rsp_t rsp
);

  localparam int W  = cia_pkg::DATA_W;
  localparam int CW = cia_pkg::BIT_CNT_W;

  logic           run_r;
  logic [CW-1:0]  cnt_r;
  logic           done_r;
  logic           neg_r;
  cia_pkg::word_t n_r;
  cia_pkg::word_t d_r;
  cia_pkg::word_t rem_r;
  cia_pkg::word_t quo_r;

  logic [W:0]     rem_sh;
  logic [W:0]     diff;
  logic           qbit;

  always_comb begin
    rem_sh = {rem_r, n_r[W-1]};
    diff   = rem_sh - {1'b0, d_r};
    qbit   = ~diff[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && run_r && (cnt_r == CW'(W));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(W)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= x[W-1] ^ y[W-1];
      n_r   <= cia_pkg::magnitude(x);
      d_r   <= cia_pkg::magnitude(y);
      rem_r <= '0;
    end else if (run_r) begin
      if (cnt_r == CW'(W)) begin
        quo_r <= neg_r ? (~n_r + cia_pkg::ONE) : n_r;
      end else begin
        rem_r <= qbit ? diff[W-1:0] : rem_sh[W-1:0];
        n_r   <= {n_r[W-2:0], qbit};
      end
    end
  end

  always_comb begin
    quo      = quo_r;
    rsp.done = done_r;
    rsp.ovf  = 1'b0;
  end

endmodule

// ----- src/cia_checker.sv -----
// ----------------------------------------------------------------------------
// cia_checker
// Port-level properties of the checked integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "checked_integer_alu_assert.svh"

module cia_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_opcode,
  input logic [63:0] in_operand_a,
  input logic [63:0] in_operand_b,
  input logic        out_valid,
  input logic [63:0] out_result,
  input logic [2:0]  out_status
);

  logic err_result;

  assign err_result = out_valid && (out_status != cia_pkg::ST_OK) && (out_result != '0);

  `CIA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `CIA_ASSERT_NEXT(a_idle_holds, !start && !busy, !busy)
  `CIA_ASSERT_NOW(a_strobe_idle, out_valid, !busy)
  `CIA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `CIA_ASSERT_NOW(a_error_zero, out_valid, !err_result)

endmodule

bind checked_integer_alu cia_checker u_cia_checker (.*);

// ----- dv/checked_integer_alu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_integer_alu_checker
// Watches the request and result ports of the checked integer ALU. Every
// accepted request is run through a wide-arithmetic model of the overflow
// checked operations, and the answer is queued. Each result strobe is then
// compared field by field with the oldest queued answer. Counts of failures,
// queued answers, checked and flagged results go back to the testbench top.
// ----------------------------------------------------------------------------
module checked_integer_alu_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  cia_pkg::code_t in_opcode,
  input  logic [63:0]    in_operand_a,
  input  logic [63:0]    in_operand_b,
  input  logic           out_valid,
  input  logic [63:0]    out_result,
  input  cia_pkg::code_t out_status,
  output int             error_count,
  output int             pending_count,
  output int             checked_count,
  output int             flagged_count
);

  typedef struct {
    logic signed [63:0] value;
    cia_pkg::code_t     status;
  } alu_answer_t;

  localparam logic signed [63:0] SIGNED_MIN = cia_pkg::MIN_VAL;

  alu_answer_t answers_due[$];
  int          errors_seen  = 0;
  int          results_seen = 0;
  int          flags_seen   = 0;
  int          outstanding  = 0;

  assign error_count   = errors_seen;
  assign pending_count = outstanding;
  assign checked_count = results_seen;
  assign flagged_count = flags_seen;

  function automatic logic product_fits(input logic signed [63:0] x,
                                        input logic signed [63:0] y,
                                        output logic signed [63:0] prod);
    logic signed [127:0] wx;
    logic signed [127:0] wy;
    logic signed [127:0] wide;
    wx   = x;
    wy   = y;
    wide = wx * wy;
    prod = wide[63:0];
    return wide[127:63] == {65{wide[63]}};
  endfunction

  function automatic alu_answer_t compute_answer(input cia_pkg::code_t op,
                                                 input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    alu_answer_t        ans;
    logic        [64:0] sum;
    logic signed [63:0] acc;
    longint             step;
    logic               fits;
    ans.value  = '0;
    ans.status = cia_pkg::ST_OK;
    case (op)
      cia_pkg::OP_ADD: begin
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63]) ans.status = cia_pkg::ST_OVF;
        else ans.value = sum[63:0];
      end
      cia_pkg::OP_SUB: begin
        sum = {a[63], a} - {b[63], b};
        if (sum[64] != sum[63]) ans.status = cia_pkg::ST_OVF;
        else ans.value = sum[63:0];
      end
      cia_pkg::OP_MUL: begin
        if (product_fits(a, b, acc)) ans.value = acc;
        else ans.status = cia_pkg::ST_OVF;
      end
      cia_pkg::OP_DIV: begin
        if (b == 0) ans.status = cia_pkg::ST_DIV0;
        else if (a == SIGNED_MIN && b == -1) ans.status = cia_pkg::ST_OVF;
        else ans.value = a / b;
      end
      cia_pkg::OP_POW: begin
        if (b < 0) ans.status = cia_pkg::ST_NEGEXP;
        else if (b == 0) ans.value = 1;
        else if (a == 0 || a == 1) ans.value = a;
        else if (a == -1) ans.value = b[0] ? -64'sd1 : 64'sd1;
        else begin
          acc  = 1;
          fits = 1'b1;
          for (step = 0; step < b && step < 65 && fits; step++)
            fits = product_fits(acc, a, acc);
          if (!fits || b > 65) ans.status = cia_pkg::ST_OVF;
          else ans.value = acc;
        end
      end
      cia_pkg::OP_FACT: begin
        if (a < 0) ans.status = cia_pkg::ST_NEGFACT;
        else begin
          acc  = 1;
          fits = 1'b1;
          for (step = 2; step <= a && step <= 70 && fits; step++)
            fits = product_fits(acc, step, acc);
          if (!fits || a > 70) ans.status = cia_pkg::ST_OVF;
          else ans.value = acc;
        end
      end
      default: begin
      end
    endcase
    if (ans.status != cia_pkg::ST_OK) ans.value = '0;
    return ans;
  endfunction

  always @(posedge clk) begin
    alu_answer_t due;
    if (rst_n) begin
      if (start && !busy)
        answers_due.push_back(compute_answer(in_opcode, signed'(in_operand_a),
                                             signed'(in_operand_b)));
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          errors_seen++;
          $error("result strobe with no request outstanding: result %0d, status %0d",
                 $signed(out_result), out_status);
        end else begin
          due = answers_due.pop_front();
          results_seen++;
          if (due.status != cia_pkg::ST_OK) flags_seen++;
          if (out_result !== due.value) begin
            errors_seen++;
            $error("result mismatch: expected %0d, got %0d", due.value,
                   $signed(out_result));
          end
          if (out_status !== due.status) begin
            errors_seen++;
            $error("status mismatch: expected %0d, got %0d", due.status, out_status);
          end
        end
      end
      outstanding = answers_due.size();
    end
  end

endmodule

// ----- dv/tb_checked_integer_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checked_integer_alu
// Stimulus and verdict for the checked integer ALU. A directed set covers
// the overflow edges of each operation, the divide, power and factorial
// special cases and the unused opcodes; a long random set follows with
// operands shaped per operation and random gaps between requests. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_checked_integer_alu;

  localparam cia_pkg::code_t OP_SPARE_LO  = 3'd6;
  localparam cia_pkg::code_t OP_SPARE_HI  = 3'd7;
  localparam int             RANDOM_COUNT = 1400;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           start;
  logic           busy;
  cia_pkg::code_t in_opcode;
  logic [63:0]    in_operand_a;
  logic [63:0]    in_operand_b;
  logic           out_valid;
  logic [63:0]    out_result;
  cia_pkg::code_t out_status;
  int             error_count;
  int             pending_count;
  int             checked_count;
  int             flagged_count;
  int             requests_sent = 0;
  logic           burst = 1'b0;

  const cia_pkg::code_t op_codes[6] = '{cia_pkg::OP_ADD, cia_pkg::OP_SUB, cia_pkg::OP_MUL,
                                        cia_pkg::OP_DIV, cia_pkg::OP_POW, cia_pkg::OP_FACT};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  checked_integer_alu DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_result   (out_result),
    .out_status   (out_status)
  );

  checked_integer_alu_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .out_valid     (out_valid),
    .out_result    (out_result),
    .out_status    (out_status),
    .error_count   (error_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .flagged_count (flagged_count)
  );

  function automatic logic [63:0] any_operand();
    logic [63:0] v;
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: v = cia_pkg::MIN_VAL + 64'($urandom_range(0, 2));
      1: v = ~cia_pkg::MIN_VAL - 64'($urandom_range(0, 2));
      2: v = 64'($urandom_range(0, 2)) - 64'd1;
      3: v = 64'($urandom_range(0, 400)) - 64'd200;
      4: v = {{32{w[31]}}, w};
      5: begin
        v = cia_pkg::MIN_VAL >> $urandom_range(0, 63);
        if (w[0]) v = -v;
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [63:0] mul_operand();
    logic [63:0] v;
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: begin
        v = 64'd3037000499 + 64'($urandom_range(0, 2)) - 64'd1;
        if (w[0]) v = -v;
      end
      1: v = {{32{w[31]}}, w};
      default: v = any_operand();
    endcase
    return v;
  endfunction

  function automatic logic [63:0] divisor_operand();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = -64'd1;
      2: begin
        v = 64'($urandom_range(1, 20));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = any_operand();
    endcase
    return v;
  endfunction

  function automatic logic [63:0] base_operand();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: v = 64'($urandom_range(0, 24)) - 64'd12;
      5: begin
        v = 64'd1 << $urandom_range(1, 8);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = any_operand();
    endcase
    return v;
  endfunction

  function automatic logic [63:0] exponent_operand();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4, 5: v = 64'($urandom_range(0, 70));
      6: v = {1'b1, $urandom, 31'($urandom)};
      default: v = any_operand();
    endcase
    return v;
  endfunction

  function automatic logic [63:0] factorial_operand();
    logic [63:0] v;
    if ($urandom_range(0, 4) != 0) v = 64'($urandom_range(0, 28)) - 64'd3;
    else v = any_operand();
    return v;
  endfunction

  task automatic send(input cia_pkg::code_t op, input logic [63:0] a,
                      input logic [63:0] b);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        = 1'b1;
    in_opcode    = op;
    in_operand_a = a;
    in_operand_b = b;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  initial begin
    cia_pkg::code_t op;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_opcode    = cia_pkg::OP_ADD;
    in_operand_a = '0;
    in_operand_b = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(cia_pkg::OP_ADD,  ~cia_pkg::MIN_VAL, 64'd1);
    send(cia_pkg::OP_ADD,  cia_pkg::MIN_VAL,  -64'd1);
    send(cia_pkg::OP_ADD,  ~cia_pkg::MIN_VAL, cia_pkg::MIN_VAL);
    send(cia_pkg::OP_SUB,  cia_pkg::MIN_VAL,  64'd1);
    send(cia_pkg::OP_SUB,  64'd0,             cia_pkg::MIN_VAL);
    send(cia_pkg::OP_SUB,  -64'd1,            cia_pkg::MIN_VAL);
    send(cia_pkg::OP_MUL,  cia_pkg::MIN_VAL,  -64'd1);
    send(cia_pkg::OP_MUL,  64'd3037000499,    64'd3037000499);
    send(cia_pkg::OP_MUL,  64'd3037000500,    64'd3037000500);
    send(cia_pkg::OP_MUL,  -(64'd1 << 32),    64'd1 << 31);
    send(cia_pkg::OP_DIV,  64'd5,             64'd0);
    send(cia_pkg::OP_DIV,  cia_pkg::MIN_VAL,  -64'd1);
    send(cia_pkg::OP_DIV,  -64'd7,            64'd2);
    send(cia_pkg::OP_POW,  64'd5,             -64'd1);
    send(cia_pkg::OP_POW,  64'd0,             64'd0);
    send(cia_pkg::OP_POW,  -64'd1,            ~cia_pkg::MIN_VAL);
    send(cia_pkg::OP_POW,  64'd2,             64'd62);
    send(cia_pkg::OP_POW,  64'd2,             64'd63);
    send(cia_pkg::OP_POW,  -64'd2,            64'd63);
    send(cia_pkg::OP_FACT, -64'd1,            64'd0);
    send(cia_pkg::OP_FACT, 64'd0,             ~cia_pkg::MIN_VAL);
    send(cia_pkg::OP_FACT, 64'd20,            64'd0);
    send(cia_pkg::OP_FACT, 64'd21,            64'd0);
    send(OP_SPARE_LO,      ~cia_pkg::MIN_VAL, cia_pkg::MIN_VAL);
    send(OP_SPARE_HI,      cia_pkg::MIN_VAL,  ~cia_pkg::MIN_VAL);

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 3)
        op = ($urandom_range(0, 1) == 1) ? OP_SPARE_HI : OP_SPARE_LO;
      else
        op = op_codes[$urandom_range(0, 5)];
      case (op)
        cia_pkg::OP_MUL:  send(op, mul_operand(), mul_operand());
        cia_pkg::OP_DIV:  send(op, any_operand(), divisor_operand());
        cia_pkg::OP_POW:  send(op, base_operand(), exponent_operand());
        cia_pkg::OP_FACT: send(op, factorial_operand(), any_operand());
        default:          send(op, any_operand(), any_operand());
      endcase
    end
    start = 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (600) @(negedge clk);

    $display("Sent %0d requests: directed overflow and special cases, then random operands",
             requests_sent);
    $display("over all eight opcode encodings; %0d results checked, %0d with a flagged status.",
             checked_count, flagged_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout: requests or results stopped advancing");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
